// ===== sv/hmlv_pkg.sv =====
// hmlv_pkg: shared constants for the height map line validator
// character codes, event kinds, result status codes, scan phases and limits
// no dependencies
`timescale 1ns / 1ps

package hmlv_pkg;

	localparam int unsigned MaxColumns = 1024;
	localparam int unsigned MaxRows    = 4096;

	localparam int unsigned COL_W   = 11;
	localparam int unsigned ROW_W   = 13;
	localparam int unsigned PHASE_W = 3;

	localparam logic [COL_W-1:0] MAX_COLS_C = COL_W'(MaxColumns);
	localparam logic [ROW_W-1:0] MAX_ROWS_C = ROW_W'(MaxRows);

	// event kinds
	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_EOL  = 2'd1;
	localparam logic [1:0] KIND_EOM  = 2'd2;

	// result status
	localparam logic [1:0] ST_LINE_OK  = 2'd0;
	localparam logic [1:0] ST_LINE_REJ = 2'd1;
	localparam logic [1:0] ST_MAP_OK   = 2'd2;
	localparam logic [1:0] ST_MAP_REJ  = 2'd3;

	// scan phases
	localparam logic [PHASE_W-1:0] PH_START  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_GAP    = 3'd1;
	localparam logic [PHASE_W-1:0] PH_DEC    = 3'd2;
	localparam logic [PHASE_W-1:0] PH_COMMA  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_COMMA0 = 3'd4;
	localparam logic [PHASE_W-1:0] PH_HEX    = 3'd5;

	// characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic               count_tok;
		logic               fail;
	} scan_res_t;

endpackage

// ===== sv/hmlv_scan.sv =====
// hmlv_scan: token grammar step for one character byte
// next scan phase, token-finished flag and syntax error flag
// depends on hmlv_pkg
`timescale 1ns / 1ps

module hmlv_scan (
	input  logic [hmlv_pkg::PHASE_W-1:0] phase,
	input  logic [7:0]                   char_byte,
	output hmlv_pkg::scan_res_t          res
);

	logic is_dig;
	logic is_hex;
	logic is_sign;

	always_comb begin
		is_dig  = char_byte inside {[hmlv_pkg::CH_0:hmlv_pkg::CH_9]};
		is_hex  = char_byte inside {[hmlv_pkg::CH_0:hmlv_pkg::CH_9],
			[hmlv_pkg::CH_LA:hmlv_pkg::CH_LF], [hmlv_pkg::CH_UA:hmlv_pkg::CH_UF]};
		is_sign = char_byte inside {hmlv_pkg::CH_PLUS, hmlv_pkg::CH_MINUS};
	end

	always_comb begin
		res.phase     = phase;
		res.count_tok = 1'b0;
		res.fail      = 1'b0;
		case (phase)
			hmlv_pkg::PH_START, hmlv_pkg::PH_GAP: begin
				if (char_byte == hmlv_pkg::CH_SPACE) begin
					res.phase = hmlv_pkg::PH_GAP;
				end else if (is_sign || is_dig) begin
					res.phase = hmlv_pkg::PH_DEC;
				end else if (char_byte == hmlv_pkg::CH_COMMA) begin
					res.phase = hmlv_pkg::PH_COMMA;
				end else begin
					res.fail = 1'b1;
				end
			end
			hmlv_pkg::PH_DEC: begin
				if (char_byte == hmlv_pkg::CH_SPACE) begin
					res.count_tok = 1'b1;
					res.phase     = hmlv_pkg::PH_GAP;
				end else if (char_byte == hmlv_pkg::CH_COMMA) begin
					res.phase = hmlv_pkg::PH_COMMA;
				end else if (!is_dig) begin
					res.fail = 1'b1;
				end
			end
			hmlv_pkg::PH_COMMA: begin
				if (char_byte == hmlv_pkg::CH_0) begin
					res.phase = hmlv_pkg::PH_COMMA0;
				end else begin
					res.fail = 1'b1;
				end
			end
			hmlv_pkg::PH_COMMA0: begin
				if (char_byte == hmlv_pkg::CH_X) begin
					res.phase = hmlv_pkg::PH_HEX;
				end else begin
					res.fail = 1'b1;
				end
			end
			hmlv_pkg::PH_HEX: begin
				if (char_byte == hmlv_pkg::CH_SPACE) begin
					res.count_tok = 1'b1;
					res.phase     = hmlv_pkg::PH_GAP;
				end else if (!is_hex) begin
					res.fail = 1'b1;
				end
			end
			default: begin
				res.fail = 1'b1;
			end
		endcase
	end

endmodule

// ===== sv/height_map_line_validator.sv =====
// height_map_line_validator: top level of the text height map checker
// input register, line/map bookkeeping and output register
// depends on hmlv_pkg and hmlv_scan
`timescale 1ns / 1ps

// Takes one event per transaction (character byte, end of line, end of map) and
// reports a status for every end of line and end of map. One event is accepted
// per clock unless the input stalls. An accepted event sits in the input register
// and its result is loaded from there into the result register, which drives
// the outputs. The input stalls only when an event that gives a result waits in
// the input register while the result register is full and stalled. Column and
// row limits are 1024 and 4096; events of kind 3 are dropped.
module height_map_line_validator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  char_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [10:0] column_count,
	output logic [12:0] row_count
);

	localparam int unsigned CW = hmlv_pkg::COL_W;
	localparam int unsigned RW = hmlv_pkg::ROW_W;

	logic                          valid_s1;
	logic [1:0]                    kind_s1;
	logic [7:0]                    char_s1;

	logic [hmlv_pkg::PHASE_W-1:0]  phase_q,  phase_d;
	logic [CW-1:0]                 tokens_q, tokens_d;
	logic [CW-1:0]                 agreed_q, agreed_d;
	logic [RW-1:0]                 rows_q,   rows_d;
	logic                          failed_q, failed_d;
	logic                          term_q,   term_d;

	logic                          res_valid;
	logic [1:0]                    res_status;
	logic [CW-1:0]                 res_cols;
	logic [RW-1:0]                 res_rows;

	logic                          gives_res;
	logic                          advance;
	logic                          out_free;
	logic [CW-1:0]                 tok_eol;
	logic                          f_eol;

	hmlv_pkg::scan_res_t           scan;

	hmlv_scan u_scan (
		.phase     (phase_q),
		.char_byte (char_s1),
		.res       (scan)
	);

	assign gives_res = (kind_s1 == hmlv_pkg::KIND_EOL) || (kind_s1 == hmlv_pkg::KIND_EOM);
	assign out_free  = !out_valid || !out_stall;
	assign advance   = valid_s1 && (!gives_res || out_free);
	assign in_stall  = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			kind_s1 <= kind;
			char_s1 <= char_byte;
		end
	end

	// state update and result for the event in the input register
	always_comb begin
		phase_d    = phase_q;
		tokens_d   = tokens_q;
		agreed_d   = agreed_q;
		rows_d     = rows_q;
		failed_d   = failed_q;
		term_d     = term_q;
		res_valid  = 1'b0;
		res_status = hmlv_pkg::ST_LINE_OK;
		res_cols   = '0;
		res_rows   = '0;
		tok_eol    = tokens_q;
		f_eol      = failed_q;
		case (kind_s1)
			hmlv_pkg::KIND_CHAR: begin
				if (!failed_q && !term_q) begin
					if (char_s1 == hmlv_pkg::CH_NUL) begin
						term_d = 1'b1;
					end else begin
						phase_d = scan.phase;
						if (scan.fail) begin
							failed_d = 1'b1;
						end else if (scan.count_tok) begin
							if (tokens_q >= hmlv_pkg::MAX_COLS_C) begin
								failed_d = 1'b1;
							end else begin
								tokens_d = tokens_q + CW'(1);
							end
						end
					end
				end
			end
			hmlv_pkg::KIND_EOL: begin
				if (failed_q) begin
					tok_eol = '0;
				end else begin
					if (phase_q == hmlv_pkg::PH_COMMA || phase_q == hmlv_pkg::PH_COMMA0) begin
						f_eol = 1'b1;
					end else if (phase_q != hmlv_pkg::PH_START) begin
						if (tokens_q >= hmlv_pkg::MAX_COLS_C) begin
							f_eol = 1'b1;
						end else begin
							tok_eol = tokens_q + CW'(1);
						end
					end
					if (!f_eol && agreed_q != '0 && tok_eol != agreed_q) begin
						f_eol = 1'b1;
					end
					if (!f_eol && rows_q >= hmlv_pkg::MAX_ROWS_C) begin
						f_eol = 1'b1;
					end
					if (!f_eol) begin
						if (agreed_q == '0) begin
							agreed_d = tok_eol;
						end
						rows_d = rows_q + RW'(1);
					end
				end
				failed_d   = f_eol;
				res_valid  = 1'b1;
				res_status = f_eol ? hmlv_pkg::ST_LINE_REJ : hmlv_pkg::ST_LINE_OK;
				res_cols   = tok_eol;
				res_rows   = rows_d;
				phase_d    = hmlv_pkg::PH_START;
				tokens_d   = '0;
				term_d     = 1'b0;
			end
			hmlv_pkg::KIND_EOM: begin
				res_valid  = 1'b1;
				res_status = (!failed_q && rows_q != '0 && agreed_q != '0) ?
					hmlv_pkg::ST_MAP_OK : hmlv_pkg::ST_MAP_REJ;
				res_cols   = agreed_q;
				res_rows   = rows_q;
				phase_d    = hmlv_pkg::PH_START;
				tokens_d   = '0;
				agreed_d   = '0;
				rows_d     = '0;
				failed_d   = 1'b0;
				term_d     = 1'b0;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= hmlv_pkg::PH_START;
			tokens_q <= '0;
			agreed_q <= '0;
			rows_q   <= '0;
			failed_q <= 1'b0;
			term_q   <= 1'b0;
		end else if (advance) begin
			phase_q  <= phase_d;
			tokens_q <= tokens_d;
			agreed_q <= agreed_d;
			rows_q   <= rows_d;
			failed_q <= failed_d;
			term_q   <= term_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && res_valid) begin
			status       <= res_status;
			column_count <= res_cols;
			row_count    <= res_rows;
		end
	end

endmodule

// ===== verif/height_map_line_validator_test.sv =====
// height_map_line_validator_test: self-checking testbench for the height map line validator
// directed event table and random maps, checked by an in-bench predictor
// depends on hmlv_pkg and height_map_line_validator
`timescale 1ns / 1ps

module height_map_line_validator_test;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam logic [7:0] CH_JUNK   = 8'hFF;

	typedef struct packed {
		logic [1:0]                 status;
		logic [hmlv_pkg::COL_W-1:0] cols;
		logic [hmlv_pkg::ROW_W-1:0] rows;
	} verdict_t;

	typedef struct packed {
		logic [1:0] ev;
		logic [7:0] ch;
		logic       pinned;
		verdict_t   want;
	} script_row_t;

	// directed events; pinned rows carry the result typed in
	localparam script_row_t SCRIPT [27] = '{
		'{hmlv_pkg::KIND_EOM,  hmlv_pkg::CH_NUL,   1'b1, '{hmlv_pkg::ST_MAP_REJ,  11'd0, 13'd0}},
		'{hmlv_pkg::KIND_EOL,  hmlv_pkg::CH_NUL,   1'b1, '{hmlv_pkg::ST_LINE_OK,  11'd0, 13'd1}},
		'{hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_MINUS, 1'b0, '0},
		'{hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_9,     1'b0, '0},
		'{hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_COMMA, 1'b0, '0},
		'{hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_0,     1'b0, '0},
		'{hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_X,     1'b0, '0},
		'{hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_LA,    1'b0, '0},
		'{hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_UF,    1'b0, '0},
		'{hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_SPACE, 1'b0, '0},
		'{hmlv_pkg::KIND_EOL,  hmlv_pkg::CH_NUL,   1'b0, '0},
		'{hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_PLUS,  1'b0, '0},
		'{hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_NUL,   1'b0, '0},
		'{hmlv_pkg::KIND_CHAR, CH_JUNK,            1'b0, '0},
		'{hmlv_pkg::KIND_EOL,  hmlv_pkg::CH_NUL,   1'b0, '0},
		'{KIND_NONE,           hmlv_pkg::CH_UA,    1'b0, '0},
		'{hmlv_pkg::KIND_EOL,  hmlv_pkg::CH_NUL,   1'b1, '{hmlv_pkg::ST_LINE_REJ, 11'd0, 13'd2}},
		'{hmlv_pkg::KIND_EOM,  hmlv_pkg::CH_NUL,   1'b0, '0},
		'{hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_COMMA, 1'b0, '0},
		'{hmlv_pkg::KIND_EOL,  hmlv_pkg::CH_NUL,   1'b1, '{hmlv_pkg::ST_LINE_REJ, 11'd0, 13'd0}},
		'{hmlv_pkg::KIND_EOM,  hmlv_pkg::CH_NUL,   1'b1, '{hmlv_pkg::ST_MAP_REJ,  11'd0, 13'd0}},
		'{hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_9,     1'b0, '0},
		'{hmlv_pkg::KIND_EOL,  hmlv_pkg::CH_NUL,   1'b0, '0},
		'{hmlv_pkg::KIND_EOM,  hmlv_pkg::CH_NUL,   1'b0, '0},
		'{hmlv_pkg::KIND_CHAR, CH_JUNK,            1'b0, '0},
		'{hmlv_pkg::KIND_EOL,  hmlv_pkg::CH_NUL,   1'b1, '{hmlv_pkg::ST_LINE_REJ, 11'd0, 13'd0}},
		'{hmlv_pkg::KIND_EOM,  hmlv_pkg::CH_NUL,   1'b1, '{hmlv_pkg::ST_MAP_REJ,  11'd0, 13'd0}}
	};

	localparam int SEND_IDLE [4]  = '{0, 71, 0, 22};
	localparam int RECV_STALL [4] = '{0, 0, 71, 22};

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic [1:0]  kind         = hmlv_pkg::KIND_CHAR;
	logic [7:0]  char_byte    = hmlv_pkg::CH_NUL;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [1:0]  status;
	logic [10:0] column_count;
	logic [12:0] row_count;

	// predictor state
	logic [hmlv_pkg::PHASE_W-1:0] scan_ph     = hmlv_pkg::PH_START;
	int unsigned                  line_tokens = 0;
	int unsigned                  agreed_cols = 0;
	int unsigned                  rows_done   = 0;
	bit                           map_bad     = 1'b0;
	bit                           line_ended  = 1'b0;

	verdict_t verdicts_due [$];
	verdict_t got;
	int       idle_pct    = 0;
	int       stall_pct   = 0;
	int       errors      = 0;
	int       events_done = 0;
	int       lines_seen  = 0;
	int       maps_seen   = 0;
	int       rejects     = 0;

	height_map_line_validator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.char_byte    (char_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.column_count (column_count),
		.row_count    (row_count)
	);

	always #5 clk = ~clk;

	function automatic bit is_dec(input logic [7:0] c);
		return c >= hmlv_pkg::CH_0 && c <= hmlv_pkg::CH_9;
	endfunction

	function automatic bit is_hex(input logic [7:0] c);
		return is_dec(c) || (c >= hmlv_pkg::CH_LA && c <= hmlv_pkg::CH_LF) ||
			(c >= hmlv_pkg::CH_UA && c <= hmlv_pkg::CH_UF);
	endfunction

	function automatic void bump_tokens();
		if (line_tokens >= hmlv_pkg::MaxColumns)
			map_bad = 1'b1;
		else
			line_tokens++;
	endfunction

	function automatic void clear_line();
		scan_ph     = hmlv_pkg::PH_START;
		line_tokens = 0;
		line_ended  = 1'b0;
	endfunction

	function automatic void scan_char(input logic [7:0] c);
		case (scan_ph)
			hmlv_pkg::PH_START, hmlv_pkg::PH_GAP: begin
				if (c == hmlv_pkg::CH_SPACE)
					scan_ph = hmlv_pkg::PH_GAP;
				else if (c == hmlv_pkg::CH_PLUS || c == hmlv_pkg::CH_MINUS || is_dec(c))
					scan_ph = hmlv_pkg::PH_DEC;
				else if (c == hmlv_pkg::CH_COMMA)
					scan_ph = hmlv_pkg::PH_COMMA;
				else
					map_bad = 1'b1;
			end
			hmlv_pkg::PH_DEC: begin
				if (c == hmlv_pkg::CH_SPACE) begin
					bump_tokens();
					scan_ph = hmlv_pkg::PH_GAP;
				end else if (c == hmlv_pkg::CH_COMMA) begin
					scan_ph = hmlv_pkg::PH_COMMA;
				end else if (!is_dec(c)) begin
					map_bad = 1'b1;
				end
			end
			hmlv_pkg::PH_COMMA: begin
				if (c == hmlv_pkg::CH_0)
					scan_ph = hmlv_pkg::PH_COMMA0;
				else
					map_bad = 1'b1;
			end
			hmlv_pkg::PH_COMMA0: begin
				if (c == hmlv_pkg::CH_X)
					scan_ph = hmlv_pkg::PH_HEX;
				else
					map_bad = 1'b1;
			end
			hmlv_pkg::PH_HEX: begin
				if (c == hmlv_pkg::CH_SPACE) begin
					bump_tokens();
					scan_ph = hmlv_pkg::PH_GAP;
				end else if (!is_hex(c)) begin
					map_bad = 1'b1;
				end
			end
			default: map_bad = 1'b1;
		endcase
	endfunction

	// advances the predicted state by one event; returns 1 when the event gives a result
	function automatic bit judge_event(input logic [1:0] ev, input logic [7:0] c,
			output verdict_t v);
		v = '0;
		if (ev == hmlv_pkg::KIND_CHAR) begin
			if (!map_bad && !line_ended) begin
				if (c == hmlv_pkg::CH_NUL)
					line_ended = 1'b1;
				else
					scan_char(c);
			end
			return 1'b0;
		end
		if (ev == hmlv_pkg::KIND_EOL) begin
			if (map_bad) begin
				line_tokens = 0;
			end else begin
				if (scan_ph == hmlv_pkg::PH_COMMA || scan_ph == hmlv_pkg::PH_COMMA0)
					map_bad = 1'b1;
				else if (scan_ph != hmlv_pkg::PH_START)
					bump_tokens();
				if (!map_bad && agreed_cols != 0 && line_tokens != agreed_cols)
					map_bad = 1'b1;
				if (!map_bad && rows_done >= hmlv_pkg::MaxRows)
					map_bad = 1'b1;
				if (!map_bad) begin
					if (agreed_cols == 0)
						agreed_cols = line_tokens;
					rows_done++;
				end
			end
			v.status = map_bad ? hmlv_pkg::ST_LINE_REJ : hmlv_pkg::ST_LINE_OK;
			v.cols   = line_tokens[hmlv_pkg::COL_W-1:0];
			v.rows   = rows_done[hmlv_pkg::ROW_W-1:0];
			clear_line();
			return 1'b1;
		end
		if (ev == hmlv_pkg::KIND_EOM) begin
			v.status = (!map_bad && rows_done != 0 && agreed_cols != 0) ?
				hmlv_pkg::ST_MAP_OK : hmlv_pkg::ST_MAP_REJ;
			v.cols   = agreed_cols[hmlv_pkg::COL_W-1:0];
			v.rows   = rows_done[hmlv_pkg::ROW_W-1:0];
			clear_line();
			agreed_cols = 0;
			rows_done   = 0;
			map_bad     = 1'b0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// one input transaction, with random sender gaps
	task automatic send_event(input logic [1:0] ev, input logic [7:0] c,
			input bit pinned = 1'b0, input verdict_t pinned_v = '0);
		verdict_t v;
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= ev;
		char_byte <= c;
		do
			@(posedge clk);
		while (in_stall);
		if (judge_event(ev, c, v))
			verdicts_due.push_back(pinned ? pinned_v : v);
		events_done++;
	endtask

	task automatic pause_until_drained();
		in_valid <= 1'b0;
		for (int w = 0; w < 100000 && verdicts_due.size() != 0; w++)
			@(posedge clk);
	endtask

	task automatic send_token();
		int s;
		s = $urandom_range(0, 3);
		if (s == 0)
			send_event(hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_PLUS);
		else if (s == 1)
			send_event(hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_MINUS);
		repeat ($urandom_range(0, 3))
			send_event(hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_0 + 8'($urandom_range(0, 9)));
		if ($urandom_range(0, 2) == 0) begin
			send_event(hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_COMMA);
			send_event(hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_0);
			send_event(hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_X);
			repeat ($urandom_range(0, 3)) begin
				s = $urandom_range(0, 21);
				if (s < 10)
					send_event(hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_0 + 8'(s));
				else if (s < 16)
					send_event(hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_LA + 8'(s - 10));
				else
					send_event(hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_UA + 8'(s - 16));
			end
		end
	endtask

	// mostly well-formed maps with random tokens, some broken lines, some pure noise
	task automatic send_random_map();
		int n_rows;
		int n_cols;
		int n;
		int fault;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 15))
				send_event(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			send_event(hmlv_pkg::KIND_EOM, hmlv_pkg::CH_NUL);
			return;
		end
		n_rows = $urandom_range(1, 6);
		n_cols = $urandom_range(1, 5);
		for (int r = 0; r < n_rows; r++) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : n_cols;
			if ($urandom_range(0, 4) == 0)
				send_event(hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_SPACE);
			for (int t = 0; t < n; t++) begin
				send_token();
				if (t < n - 1)
					repeat ($urandom_range(1, 3))
						send_event(hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_SPACE);
			end
			fault = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 5) : -1;
			case (fault)
				0: send_event(hmlv_pkg::KIND_CHAR, 8'($urandom_range(0, 255)));
				1: begin
					send_event(hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_NUL);
					repeat ($urandom_range(1, 3))
						send_event(hmlv_pkg::KIND_CHAR, 8'($urandom_range(0, 255)));
				end
				2: begin
					send_event(hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_COMMA);
					if ($urandom_range(0, 1) == 1)
						send_event(hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_0);
				end
				3: send_event(hmlv_pkg::KIND_CHAR, hmlv_pkg::CH_SPACE);
				4: send_event(KIND_NONE, 8'($urandom_range(0, 255)));
				default: ;
			endcase
			// unfinished last line is dropped at end of map
			if (!(fault == 5 && r == n_rows - 1))
				send_event(hmlv_pkg::KIND_EOL, hmlv_pkg::CH_NUL);
		end
		send_event(hmlv_pkg::KIND_EOM, hmlv_pkg::CH_NUL);
	endtask

	task automatic note_mismatch(input string field, input int unsigned want,
			input int unsigned seen);
		errors++;
		$display("%0t mismatch %s: expected %0d, actual %0d", $time, field, want, seen);
	endtask

	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	// result transaction check
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (verdicts_due.size() == 0) begin
				note_mismatch("unexpected result, status", 0, status);
			end else begin
				got = verdicts_due.pop_front();
				if (status !== got.status)
					note_mismatch("status", got.status, status);
				if (column_count !== got.cols)
					note_mismatch("column_count", got.cols, column_count);
				if (row_count !== got.rows)
					note_mismatch("row_count", got.rows, row_count);
				if (status == hmlv_pkg::ST_LINE_OK || status == hmlv_pkg::ST_LINE_REJ)
					lines_seen++;
				else
					maps_seen++;
				if (status == hmlv_pkg::ST_LINE_REJ || status == hmlv_pkg::ST_MAP_REJ)
					rejects++;
			end
		end
	end

	initial begin
		int target;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (SCRIPT[i])
			send_event(SCRIPT[i].ev, SCRIPT[i].ch, SCRIPT[i].pinned, SCRIPT[i].want);
		pause_until_drained();

		for (int p = 0; p < 4; p++) begin
			idle_pct  = SEND_IDLE[p];
			stall_pct = RECV_STALL[p];
			target    = events_done + 268;
			while (events_done < target)
				send_random_map();
			pause_until_drained();
		end

		repeat (10) @(posedge clk);
		if (verdicts_due.size() != 0)
			note_mismatch("results never delivered, count", 0, verdicts_due.size());
		$display("sent %0d events; checked %0d line and %0d map results, %0d of them rejects",
			events_done, lines_seen, maps_seen, rejects);
		$display("covered token grammar, zero bytes, broken hex prefixes, stray kinds and stalls");
		if (errors == 0)
			$display("PASS height_map_line_validator");
		else
			$display("FAIL height_map_line_validator");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL height_map_line_validator");
		$finish;
	end

endmodule
